// ===== hw/rtl/smx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Types and constants shared by the smoothed maximum search block.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;
    localparam int PIXEL_W    = 16;
    localparam int CSUM_W     = PIXEL_W + 2;
    localparam int SUM_W      = 20;
    localparam int COORD_W    = 10;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int SLICE_W    = 8;
    localparam int POS_W      = SLICE_W + 1;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic signed [PIXEL_W-1:0] pixel_t;
    typedef logic signed [CSUM_W-1:0]  csum_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel;
        logic [SLICE_W-1:0]        plane_number;
        logic [SLICE_W-1:0]        frame_number;
        logic                      end_of_image;
    } pix_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        logic [COORD_W-1:0]      max_column;
        logic [COORD_W-1:0]      max_row;
        logic [POS_W-1:0]        max_plane;
        logic [POS_W-1:0]        max_frame;
    } res_item_t;

    // Position and flags of one item as it moves down the pipeline.
    typedef struct packed {
        logic               valid;
        logic               eoi;
        logic               window;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [POS_W-1:0]   plane;
        logic [POS_W-1:0]   frame;
    } stage_ctl_t;

endpackage

// ===== hw/rtl/smx_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pixel_if
// Valid/ready channel carrying one input pixel item.
// ----------------------------------------------------------------------------
interface smx_pixel_if;
    logic              valid;
    logic              ready;
    smx_pkg::pix_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smx_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_result_if
// Valid/ready channel carrying one search result item.
// ----------------------------------------------------------------------------
interface smx_result_if;
    logic              valid;
    logic              ready;
    smx_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smx_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface smx_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [smx_pkg::CFG_IDX_W-1:0]   index;
    logic [smx_pkg::DIM_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/smoothed_max_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_max_search
// Streaming search for the largest 3x3 weighted sum and its position.
// ----------------------------------------------------------------------------
// The block takes one pixel item every clock cycle unless the pipeline is halted.
// Its four pipeline stages are input register with line-store read, window column
// update, window sum, and the running maximum compare that loads the result
// register. The single result item is offered once the compare stage has taken
// the item flagged end_of_image. A waiting result does not hold up the input; the
// pipeline halts only when the next end-of-image item reaches the compare stage
// while the earlier result is still waiting to be taken. The line stores are two
// single-port-write memories of one row each, written one address per item. Width
// and height must be written through the configuration channel while the block
// is idle (not enforced by the block); values below 3 act as 3, above 1024 as 1024.
module smoothed_max_search (
    input  logic clk,
    input  logic rst_n,
    smx_pixel_if.sink    pix,
    smx_cfg_if.sink      cfg,
    smx_result_if.source result
);

    logic [smx_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [smx_pkg::DIM_W-1:0]   width_lim, height_lim;
    logic [smx_pkg::COORD_W-1:0] col_cnt_reg, row_cnt_reg;
    logic [smx_pkg::COORD_W-1:0] col_cnt_next, row_cnt_next;
    smx_pkg::stage_ctl_t         s1_ctl_reg;
    smx_pkg::pixel_t             s1_px_reg;
    smx_pkg::stage_ctl_t         s3_ctl;
    smx_pkg::sum_t               s3_sum;
    smx_pkg::pixel_t             rd_upper, rd_middle;
    logic                        en;
    logic                        accept;
    logic                        col_wrap;

    // Only a second result meeting a waiting one stops the pipeline.
    assign en      = !(result.valid && !result.ready && s3_ctl.valid && s3_ctl.eoi);
    assign pix.ready = en;
    assign accept  = pix.valid && en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= smx_pkg::DIM_W'(smx_pkg::MAX_WIDTH);
            height_reg <= smx_pkg::DIM_W'(smx_pkg::MAX_HEIGHT);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                smx_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                smx_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < smx_pkg::DIM_W'(smx_pkg::MIN_DIM))
            width_lim = smx_pkg::DIM_W'(smx_pkg::MIN_DIM);
        else if (width_reg > smx_pkg::DIM_W'(smx_pkg::MAX_WIDTH))
            width_lim = smx_pkg::DIM_W'(smx_pkg::MAX_WIDTH);
        else
            width_lim = width_reg;

        if (height_reg < smx_pkg::DIM_W'(smx_pkg::MIN_DIM))
            height_lim = smx_pkg::DIM_W'(smx_pkg::MIN_DIM);
        else if (height_reg > smx_pkg::DIM_W'(smx_pkg::MAX_HEIGHT))
            height_lim = smx_pkg::DIM_W'(smx_pkg::MAX_HEIGHT);
        else
            height_lim = height_reg;
    end

    assign col_wrap = (smx_pkg::DIM_W'(col_cnt_reg) + smx_pkg::DIM_W'(1)) >= width_lim;

    always_comb
    begin
        col_cnt_next = col_cnt_reg + smx_pkg::COORD_W'(1);
        row_cnt_next = row_cnt_reg;
        if (pix.data.end_of_image)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (col_wrap)
        begin
            col_cnt_next = '0;
            if ((smx_pkg::DIM_W'(row_cnt_reg) + smx_pkg::DIM_W'(1)) >= height_lim)
                row_cnt_next = '0;
            else
                row_cnt_next = row_cnt_reg + smx_pkg::COORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            s1_ctl_reg  <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                col_cnt_reg       <= col_cnt_next;
                row_cnt_reg       <= row_cnt_next;
                s1_ctl_reg.valid  <= 1'b1;
                s1_ctl_reg.eoi    <= pix.data.end_of_image;
                s1_ctl_reg.window <= (row_cnt_reg >= smx_pkg::COORD_W'(2))
                                  && (col_cnt_reg >= smx_pkg::COORD_W'(2));
                s1_ctl_reg.col    <= col_cnt_reg;
                s1_ctl_reg.row    <= row_cnt_reg;
                s1_ctl_reg.plane  <= smx_pkg::POS_W'(pix.data.plane_number)
                                  + smx_pkg::POS_W'(1);
                s1_ctl_reg.frame  <= smx_pkg::POS_W'(pix.data.frame_number)
                                  + smx_pkg::POS_W'(1);
            end
            else
            begin
                s1_ctl_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg <= pix.data.pixel;
        end
    end

    smx_line_buffer u_line_buffer (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_cnt_reg[smx_pkg::ADDR_W-1:0]),
        .wr_en     (en && s1_ctl_reg.valid),
        .wr_addr   (s1_ctl_reg.col[smx_pkg::ADDR_W-1:0]),
        .wr_pixel  (s1_px_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    smx_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s1_ctl    (s1_ctl_reg),
        .s1_pixel  (s1_px_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .s3_ctl    (s3_ctl),
        .s3_sum    (s3_sum)
    );

    smx_best_track u_best_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s3_ctl    (s3_ctl),
        .s3_sum    (s3_sum),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_data  (result.data)
    );

    // A new result only follows an end-of-image item leaving the compare stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(s3_ctl.valid && s3_ctl.eoi && en))
        else $error("result raised without an end-of-image item");

    // The position counters restart after the last pixel of an image.
    a_counter_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.data.end_of_image)
            |=> (col_cnt_reg == '0 && row_cnt_reg == '0))
        else $error("counters not cleared after end of image");

    // The first stage only fills from an accepted item.
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_ctl_reg.valid) |-> $past(pix.valid && pix.ready))
        else $error("input stage filled without an accepted item");

endmodule

// ===== hw/rtl/smx_line_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_line_buffer
// Two line stores holding the previous two rows, with registered reads.
// ----------------------------------------------------------------------------
module smx_line_buffer (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [smx_pkg::ADDR_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [smx_pkg::ADDR_W-1:0]  wr_addr,
    input  smx_pkg::pixel_t             wr_pixel,
    output smx_pkg::pixel_t             rd_upper,
    output smx_pkg::pixel_t             rd_middle
);

    smx_pkg::pixel_t upper_mem [smx_pkg::MAX_WIDTH];
    smx_pkg::pixel_t middle_mem [smx_pkg::MAX_WIDTH];
    smx_pkg::pixel_t rd_upper_reg;
    smx_pkg::pixel_t rd_middle_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            // A read of the address being written in the same cycle takes the new values.
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_upper_reg  <= rd_middle_reg;
                rd_middle_reg <= wr_pixel;
            end
            else
            begin
                rd_upper_reg  <= upper_mem[rd_addr];
                rd_middle_reg <= middle_mem[rd_addr];
            end
        end
    end

    // The middle row moves up; the old middle value is still in the read register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= rd_middle_reg;
            middle_mem[wr_addr] <= wr_pixel;
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

// ===== hw/rtl/smx_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_window
// 3x3 window kept as column sums, and the weighted window sum stage.
// ----------------------------------------------------------------------------
module smx_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  smx_pkg::stage_ctl_t s1_ctl,
    input  smx_pkg::pixel_t     s1_pixel,
    input  smx_pkg::pixel_t     rd_upper,
    input  smx_pkg::pixel_t     rd_middle,
    output smx_pkg::stage_ctl_t s3_ctl,
    output smx_pkg::sum_t       s3_sum
);

    smx_pkg::csum_t      cs0_reg, cs1_reg, cs2_reg;
    smx_pkg::pixel_t     mc1_reg, mc2_reg;
    smx_pkg::stage_ctl_t s2_ctl_reg, s3_ctl_reg;
    smx_pkg::sum_t       s3_sum_reg;
    smx_pkg::csum_t      col_sum;
    smx_pkg::sum_t       win_sum;

    assign col_sum = smx_pkg::csum_t'(rd_upper) + smx_pkg::csum_t'(rd_middle)
                   + smx_pkg::csum_t'(s1_pixel);

    // All nine pixels plus the center once more.
    assign win_sum = smx_pkg::sum_t'(cs0_reg) + smx_pkg::sum_t'(cs1_reg)
                   + smx_pkg::sum_t'(cs2_reg) + smx_pkg::sum_t'(mc1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs0_reg    <= '0;
            cs1_reg    <= '0;
            cs2_reg    <= '0;
            mc1_reg    <= '0;
            mc2_reg    <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            if (s1_ctl.valid)
            begin
                cs0_reg <= cs1_reg;
                cs1_reg <= cs2_reg;
                cs2_reg <= col_sum;
                mc1_reg <= mc2_reg;
                mc2_reg <= rd_middle;
            end
            s2_ctl_reg <= s1_ctl;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sum_reg <= win_sum;
        end
    end

    assign s3_ctl = s3_ctl_reg;
    assign s3_sum = s3_sum_reg;

endmodule

// ===== hw/rtl/smx_best_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_best_track
// Running maximum with position, and the result register.
// ----------------------------------------------------------------------------
module smx_best_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  smx_pkg::stage_ctl_t s3_ctl,
    input  smx_pkg::sum_t       s3_sum,
    input  logic                res_ready,
    output logic                res_valid,
    output smx_pkg::res_item_t  res_data
);

    smx_pkg::sum_t                  best_sum_reg;
    logic [smx_pkg::COORD_W-1:0]    best_col_reg, best_row_reg;
    logic [smx_pkg::POS_W-1:0]      best_plane_reg, best_frame_reg;
    logic                           found_reg;
    logic                           res_valid_reg;
    smx_pkg::res_item_t             res_data_reg;

    logic               earlier;
    logic               take;
    smx_pkg::res_item_t best_next;

    always_comb
    begin
        if (s3_ctl.plane != best_plane_reg)
            earlier = s3_ctl.plane < best_plane_reg;
        else if (s3_ctl.row != best_row_reg)
            earlier = s3_ctl.row < best_row_reg;
        else if (s3_ctl.col != best_col_reg)
            earlier = s3_ctl.col < best_col_reg;
        else
            earlier = s3_ctl.frame < best_frame_reg;
    end

    assign take = s3_ctl.valid && s3_ctl.window
               && (!found_reg || (s3_sum > best_sum_reg)
                   || ((s3_sum == best_sum_reg) && earlier));

    always_comb
    begin
        if (take)
        begin
            best_next.max_sum    = s3_sum;
            best_next.max_column = s3_ctl.col;
            best_next.max_row    = s3_ctl.row;
            best_next.max_plane  = s3_ctl.plane;
            best_next.max_frame  = s3_ctl.frame;
        end
        else
        begin
            best_next.max_sum    = best_sum_reg;
            best_next.max_column = best_col_reg;
            best_next.max_row    = best_row_reg;
            best_next.max_plane  = best_plane_reg;
            best_next.max_frame  = best_frame_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg   <= '0;
            best_col_reg   <= smx_pkg::COORD_W'(1);
            best_row_reg   <= smx_pkg::COORD_W'(1);
            best_plane_reg <= smx_pkg::POS_W'(1);
            best_frame_reg <= smx_pkg::POS_W'(1);
            found_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // The result register holds its item until taken, apart from the pipeline.
            if (en && s3_ctl.valid && s3_ctl.eoi)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;

            if (en)
            begin
                if (s3_ctl.valid && s3_ctl.eoi)
                begin
                    // The search starts over after each image.
                    best_sum_reg   <= '0;
                    best_col_reg   <= smx_pkg::COORD_W'(1);
                    best_row_reg   <= smx_pkg::COORD_W'(1);
                    best_plane_reg <= smx_pkg::POS_W'(1);
                    best_frame_reg <= smx_pkg::POS_W'(1);
                    found_reg      <= 1'b0;
                end
                else if (take)
                begin
                    best_sum_reg   <= best_next.max_sum;
                    best_col_reg   <= best_next.max_column;
                    best_row_reg   <= best_next.max_row;
                    best_plane_reg <= best_next.max_plane;
                    best_frame_reg <= best_next.max_frame;
                    found_reg      <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s3_ctl.valid && s3_ctl.eoi)
        begin
            res_data_reg <= best_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== tb/tb_smoothed_max_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_max_search
// Self-checking bench for the streaming 3x3 smoothed maximum search.
// Pixel items are driven through the pixel channel with random gaps, and
// every accepted item is run through a local model of the line stores, the
// window and the running maximum. Each result item is compared field by
// field with the oldest predicted peak. The run covers reset values,
// saturated pixels, clamped image sizes, a resize in the middle
// of an image, a long result stall, and a long stretch of random images.
// ----------------------------------------------------------------------------
module tb_smoothed_max_search;

    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int STALL_CYCLES = 150;
    localparam int RANDOM_ITEMS = 680;
    localparam int QUIET_TAIL   = 560;

    typedef enum int {STYLE_FLAT, STYLE_TINY, STYLE_RAIL, STYLE_FULL} pixel_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smx_pixel_if  pix_ch();
    smx_cfg_if    cfg_ch();
    smx_result_if res_ch();

    smoothed_max_search dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // Local copy of the block state.
    smx_pkg::pixel_t           line_up  [smx_pkg::MAX_WIDTH];
    smx_pkg::pixel_t           line_mid [smx_pkg::MAX_WIDTH];
    smx_pkg::pixel_t           win [9];
    int unsigned               col_cnt;
    int unsigned               row_cnt;
    int                        best_sum;
    int unsigned               best_col;
    int unsigned               best_row;
    int unsigned               best_plane;
    int unsigned               best_frame;
    bit                        found;
    logic [smx_pkg::DIM_W-1:0] width_reg;
    logic [smx_pkg::DIM_W-1:0] height_reg;

    smx_pkg::res_item_t expected_peaks [$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int src_idle_pct  = 20;
    int sink_idle_pct = 20;
    int hold_cycles   = 0;
    int random_items  = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [smx_pkg::DIM_W-1:0] v,
                                              input int unsigned top);
        if (v < smx_pkg::MIN_DIM)
            return smx_pkg::MIN_DIM;
        if (v > top)
            return top;
        return v;
    endfunction

    task automatic clear_peak();
        col_cnt    = 0;
        row_cnt    = 0;
        best_sum   = 0;
        best_col   = 1;
        best_row   = 1;
        best_plane = 1;
        best_frame = 1;
        found      = 1'b0;
    endtask

    // Advances the local model by one pixel item and queues the peak that
    // the block reports when the item closes the image.
    task automatic track_peak(input smx_pkg::pix_item_t it);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        int unsigned        pl;
        int unsigned        fr;
        int                 s;
        bit                 earlier;
        smx_pkg::res_item_t peak;
        w  = clamp_dim(width_reg, smx_pkg::MAX_WIDTH);
        h  = clamp_dim(height_reg, smx_pkg::MAX_HEIGHT);
        c  = col_cnt;
        r  = row_cnt;
        pl = it.plane_number + 1;
        fr = it.frame_number + 1;
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2]      = line_up[c];
        win[5]      = line_mid[c];
        win[8]      = it.pixel;
        line_up[c]  = line_mid[c];
        line_mid[c] = it.pixel;

        if (r >= 2 && c >= 2)
        begin
            // The center counts twice, so it is added once before the loop.
            s = win[4];
            for (int k = 0; k < 9; k++)
                s += win[k];
            if (pl != best_plane)
                earlier = pl < best_plane;
            else if (r != best_row)
                earlier = r < best_row;
            else if (c != best_col)
                earlier = c < best_col;
            else
                earlier = fr < best_frame;
            if (!found || s > best_sum || (s == best_sum && earlier))
            begin
                best_sum   = s;
                best_col   = c;
                best_row   = r;
                best_plane = pl;
                best_frame = fr;
                found      = 1'b1;
            end
        end

        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end

        if (it.end_of_image)
        begin
            peak.max_sum    = best_sum[smx_pkg::SUM_W-1:0];
            peak.max_column = best_col[smx_pkg::COORD_W-1:0];
            peak.max_row    = best_row[smx_pkg::COORD_W-1:0];
            peak.max_plane  = best_plane[smx_pkg::POS_W-1:0];
            peak.max_frame  = best_frame[smx_pkg::POS_W-1:0];
            expected_peaks.push_back(peak);
            clear_peak();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item
    // is taken, with valid still high so the next item can follow at once.
    task automatic send_pixel(input smx_pkg::pix_item_t it);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        track_peak(it);
        @(negedge clk);
    endtask

    task automatic send_flat(input int n, input smx_pkg::pixel_t px,
                             input logic [smx_pkg::SLICE_W-1:0] pl,
                             input logic [smx_pkg::SLICE_W-1:0] fr);
        smx_pkg::pix_item_t it;
        it.pixel        = px;
        it.plane_number = pl;
        it.frame_number = fr;
        for (int k = 0; k < n; k++)
        begin
            it.end_of_image = (k == n - 1);
            send_pixel(it);
        end
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [smx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smx_pkg::DIM_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == smx_pkg::REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // One image of one or two slices at the current size. Most images are
    // well formed; about one in ten ends early and carries noise positions.
    task automatic send_random_image();
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 span;
        int unsigned                 cut;
        bit                          broken;
        pixel_style_t                style;
        smx_pkg::pixel_t             flat;
        logic [smx_pkg::SLICE_W-1:0] base_plane;
        logic [smx_pkg::SLICE_W-1:0] pl;
        logic [smx_pkg::SLICE_W-1:0] fr;
        smx_pkg::pix_item_t          it;
        w          = clamp_dim(width_reg, smx_pkg::MAX_WIDTH);
        h          = clamp_dim(height_reg, smx_pkg::MAX_HEIGHT);
        span       = w * h * $urandom_range(1, 2);
        broken     = ($urandom_range(0, 9) == 0);
        cut        = broken ? $urandom_range(1, span) : span;
        style      = pixel_style_t'($urandom_range(0, 3));
        flat       = smx_pkg::pixel_t'($urandom);
        base_plane = smx_pkg::SLICE_W'($urandom);
        pl         = base_plane;
        fr         = '0;
        for (int unsigned k = 0; k < cut; k++)
        begin
            if (broken)
            begin
                pl = smx_pkg::SLICE_W'($urandom);
                fr = smx_pkg::SLICE_W'($urandom);
            end
            else if (k % (w * h) == 0)
            begin
                // Close plane numbers and few frames make ties likely.
                pl = base_plane + smx_pkg::SLICE_W'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    fr = smx_pkg::SLICE_W'($urandom_range(0, 2));
                else
                    fr = smx_pkg::SLICE_W'($urandom);
            end
            case (style)
                STYLE_FLAT: it.pixel = flat;
                STYLE_TINY: it.pixel = smx_pkg::pixel_t'(int'($urandom_range(0, 3)) - 2);
                STYLE_RAIL: it.pixel = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
                default:    it.pixel = smx_pkg::pixel_t'($urandom);
            endcase
            it.plane_number = pl;
            it.frame_number = fr;
            it.end_of_image = (k == cut - 1);
            send_pixel(it);
            random_items++;
        end
    endtask

    // Reset size of 1024 x 1024: no window can complete in a few items, so
    // both results carry a zero sum and the reset position of 1 in every field.
    task automatic test_reset_defaults();
        smx_pkg::pix_item_t it;
        it.pixel        = smx_pkg::pixel_t'($urandom);
        it.plane_number = smx_pkg::SLICE_W'($urandom);
        it.frame_number = smx_pkg::SLICE_W'($urandom);
        it.end_of_image = 1'b1;
        send_pixel(it);
        for (int k = 0; k < 6; k++)
        begin
            it.pixel        = smx_pkg::pixel_t'($urandom);
            it.end_of_image = (k == 5);
            send_pixel(it);
        end
        wait_idle();
    endtask

    task automatic test_signal_extremes();
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(3));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(3));
        send_flat(9, 16'sh7FFF, 8'hFF, 8'hFF);
        send_flat(9, 16'sh8000, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic test_dimension_limits();
        smx_pkg::pix_item_t it;
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(0));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(1));
        send_random_image();
        wait_idle();
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(2));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(2));
        send_random_image();
        wait_idle();
        // An oversize width acts as the maximum; this short image stays in
        // the first row.
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(2047));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(smx_pkg::MAX_HEIGHT));
        it.plane_number = smx_pkg::SLICE_W'($urandom);
        it.frame_number = smx_pkg::SLICE_W'($urandom);
        for (int k = 0; k < 16; k++)
        begin
            it.pixel        = smx_pkg::pixel_t'($urandom);
            it.end_of_image = (k == 15);
            send_pixel(it);
        end
        wait_idle();
    endtask

    // Shrinks both sizes while the counters sit past the new limits.
    task automatic test_mid_image_resize();
        smx_pkg::pix_item_t it;
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(6));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(5));
        it.plane_number = smx_pkg::SLICE_W'($urandom);
        it.frame_number = smx_pkg::SLICE_W'($urandom);
        it.end_of_image = 1'b0;
        for (int k = 0; k < 6 * 3 + 4; k++)
        begin
            it.pixel = smx_pkg::pixel_t'($urandom);
            send_pixel(it);
        end
        wait_idle();
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(4));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(3));
        for (int k = 0; k < 13; k++)
        begin
            it.pixel        = smx_pkg::pixel_t'($urandom);
            it.end_of_image = (k == 12);
            send_pixel(it);
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(smx_pkg::REG_IMAGE_WIDTH, smx_pkg::DIM_W'(3));
        write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'(3));
        src_idle_pct = 0;
        hold_cycles  = STALL_CYCLES;
        repeat (8) send_flat(9, smx_pkg::pixel_t'($urandom), smx_pkg::SLICE_W'($urandom),
                             smx_pkg::SLICE_W'($urandom));
        wait_idle();
        src_idle_pct = 20;
    endtask

    task automatic test_random_images();
        int pick;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= QUIET_TAIL)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                pick          = $urandom_range(0, 2);
                src_idle_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
                pick          = $urandom_range(0, 2);
                sink_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                if ($urandom_range(0, 7) == 0)
                    write_reg(smx_pkg::REG_IMAGE_WIDTH,
                              smx_pkg::DIM_W'($urandom_range(9, 24)));
                else
                    write_reg(smx_pkg::REG_IMAGE_WIDTH,
                              smx_pkg::DIM_W'($urandom_range(0, 7)));
                write_reg(smx_pkg::REG_IMAGE_HEIGHT, smx_pkg::DIM_W'($urandom_range(0, 5)));
            end
            send_random_image();
        end
    endtask

    initial begin : stimulus
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= smx_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data  <= '0;
        width_reg  = smx_pkg::DIM_W'(smx_pkg::MAX_WIDTH);
        height_reg = smx_pkg::DIM_W'(smx_pkg::MAX_HEIGHT);
        for (int k = 0; k < smx_pkg::MAX_WIDTH; k++)
        begin
            line_up[k]  = '0;
            line_mid[k] = '0;
        end
        for (int k = 0; k < 9; k++)
            win[k] = '0;
        clear_peak();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_signal_extremes();
        test_dimension_limits();
        test_mid_image_resize();
        test_output_backpressure();
        test_random_images();
        wait_idle();

        if (mismatches == 0)
            $display("tb_smoothed_max_search: clean");
        else
            $display("tb_smoothed_max_search: errors");
        $finish;
    end

    // Result ready: a requested long stall first, then random idle bursts.
    initial begin : result_drain
        int gap;
        gap = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                gap--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
                    gap = $urandom_range(1, 11);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : peak_check
        smx_pkg::res_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_peaks.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with none expected, actual sum %0d", $time,
                         res_ch.data.max_sum);
            end
            else
            begin
                want = expected_peaks.pop_front();
                check_field("max_sum", want.max_sum, res_ch.data.max_sum);
                check_field("max_column", want.max_column, res_ch.data.max_column);
                check_field("max_row", want.max_row, res_ch.data.max_row);
                check_field("max_plane", want.max_plane, res_ch.data.max_plane);
                check_field("max_frame", want.max_frame, res_ch.data.max_frame);
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
                     QUIET_LIMIT, expected_peaks.size());
            $display("tb_smoothed_max_search: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
hw/rtl/smx_pkg.sv
hw/rtl/smx_pixel_if.sv
hw/rtl/smx_result_if.sv
hw/rtl/smx_cfg_if.sv
hw/rtl/smx_line_buffer.sv
hw/rtl/smx_window.sv
hw/rtl/smx_best_track.sv
hw/rtl/smoothed_max_search.sv
tb/tb_smoothed_max_search.sv
